FILE: design/bpc_pkg.sv
package bpc_pkg;

  localparam int DIV_N = 32;  // dividend and quotient width of the long dividers
  localparam int DEN_W = 20;  // divisor width of the long dividers
  localparam int X1_W  = 19;  // temperature term x1

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OSS     = 3'd5;

  localparam logic signed [30:0] B6_OFS   = 31'sd4000;
  localparam logic        [31:0] B4_OFS   = 32'd32768;
  localparam logic        [11:0] SQ_COEF  = 12'd3038;
  localparam logic signed [14:0] P_COEF   = -15'sd7357;
  localparam logic signed [47:0] P_OFS    = 48'sd3791;
  localparam logic        [17:0] PRESS_MAX = 18'h3FFFF;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic        [15:0] ac4;
    logic        [15:0] ac5;
    logic        [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic        [1:0]  oss;
  } cal_t;

  // travels beside a sample through both dividers
  typedef struct packed {
    logic                   err;
    logic                   neg;
    logic                   b7hi;
    logic signed [X1_W-1:0] x1;
    logic        [23:0]     up;
    logic signed [15:0]     temp;
  } side_t;

  function automatic logic [15:0] press_scale(input logic [1:0] oss);
    logic [15:0] s;
    case (oss)
      2'd0:    s = 16'd50000;
      2'd1:    s = 16'd25000;
      2'd2:    s = 16'd12500;
      default: s = 16'd6250;
    endcase
    return s;
  endfunction

endpackage

FILE: design/bpc_div.sv
module bpc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [bpc_pkg::DIV_N-1:0]  in_num,
  input  logic [bpc_pkg::DEN_W-1:0]  in_den,
  input  bpc_pkg::side_t             in_side,
  output logic                       out_v,
  output logic [bpc_pkg::DIV_N-1:0]  out_q,
  output bpc_pkg::side_t             out_side
);
  import bpc_pkg::*;

  // restoring division, one quotient bit per stage
  logic             v_r    [DIV_N];
  logic [DEN_W-1:0] rem_r  [DIV_N];
  logic [DEN_W-1:0] den_r  [DIV_N];
  logic [DIV_N-1:0] num_r  [DIV_N];
  logic [DIV_N-1:0] q_r    [DIV_N];
  side_t            side_r [DIV_N];

  genvar k;
  for (k = 0; k < DIV_N; k++) begin : g_stage
    logic             pv;
    logic [DEN_W-1:0] prem;
    logic [DEN_W-1:0] pden;
    logic [DIV_N-1:0] pnum;
    logic [DIV_N-1:0] pq;
    side_t            pside;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign pv    = in_v;
      assign prem  = '0;
      assign pden  = in_den;
      assign pnum  = in_num;
      assign pq    = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign prem  = rem_r[k-1];
      assign pden  = den_r[k-1];
      assign pnum  = num_r[k-1];
      assign pq    = q_r[k-1];
      assign pside = side_r[k-1];
    end

    always_comb begin
      trial   = {prem, pnum[DIV_N-1]};
      diff    = trial - {1'b0, pden};
      ge      = (trial >= {1'b0, pden});
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= pden;
        num_r[k]  <= {pnum[DIV_N-2:0], 1'b0};
        q_r[k]    <= {pq[DIV_N-2:0], ge};
        side_r[k] <= pside;
      end
    end
  end

  assign out_v    = v_r[DIV_N-1];
  assign out_q    = q_r[DIV_N-1];
  assign out_side = side_r[DIV_N-1];

endmodule

FILE: design/bpc_coef.sv
module bpc_coef (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  bpc_pkg::cal_t      cal,
  input  logic               in_v,
  input  logic signed [29:0] in_b5,
  input  bpc_pkg::side_t     in_side,
  output logic               out_v,
  output logic [16:0]        out_b4,
  output logic [31:0]        out_b7,
  output bpc_pkg::side_t     out_side
);
  import bpc_pkg::*;

  logic  v_r [6];
  side_t side_r [6];

  logic signed [30:0] c1_b6_r;
  logic signed [61:0] c2_sq_r;
  logic signed [46:0] c2_ac2_r, c2_ac3_r;
  logic signed [65:0] c3_b2_r, c3_b1_r;
  logic signed [35:0] c3_xa2_r;
  logic signed [33:0] c3_xa3_r;
  logic signed [60:0] c4_b3_r;
  logic        [31:0] c4_tmp_r;
  logic        [16:0] c5_b4_r;
  logic        [31:0] c5_diff_r;
  logic        [16:0] c6_b4_r;
  logic        [31:0] c6_b7_r;

  logic signed [49:0] sq;
  logic signed [54:0] x1;
  logic signed [55:0] x3;
  logic signed [17:0] ac1x4;
  logic signed [56:0] v0;
  logic signed [59:0] v1;
  logic signed [60:0] v2;
  logic signed [60:0] b3;
  logic signed [49:0] xb1;
  logic signed [50:0] xbs;
  logic signed [50:0] xb;
  logic        [47:0] prod4;
  logic signed [60:0] upx;
  logic signed [60:0] diff;
  logic        [47:0] prod5;

  always_comb begin
    sq    = c2_sq_r[61:12];
    x1    = c3_b2_r[65:11];
    x3    = x1 + c3_xa2_r;
    ac1x4 = {cal.ac1, 2'b00};
    v0    = x3 + ac1x4;
    v1    = v0 <<< cal.oss;
    v2    = v1 + 61'sd2;
    b3    = (v2 + (v2[60] ? 61'sd3 : 61'sd0)) >>> 2;
    xb1   = c3_b1_r[65:16];
    xbs   = xb1 + c3_xa3_r + 51'sd2;
    xb    = xbs >>> 2;
    prod4 = cal.ac4 * c4_tmp_r;
    upx   = {37'd0, side_r[3].up};
    diff  = upx - c4_b3_r;
    prod5 = c5_diff_r * press_scale(cal.oss);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int i = 1; i < 6; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int i = 1; i < 6; i++) side_r[i] <= side_r[i-1];
      c1_b6_r   <= in_b5 - B6_OFS;
      c2_sq_r   <= c1_b6_r * c1_b6_r;
      c2_ac2_r  <= cal.ac2 * c1_b6_r;
      c2_ac3_r  <= cal.ac3 * c1_b6_r;
      c3_b2_r   <= cal.b2 * sq;
      c3_b1_r   <= cal.b1 * sq;
      c3_xa2_r  <= c2_ac2_r[46:11];
      c3_xa3_r  <= c2_ac3_r[46:13];
      c4_b3_r   <= b3;
      c4_tmp_r  <= xb[31:0] + B4_OFS;
      c5_b4_r   <= prod4[31:15];
      c5_diff_r <= diff[31:0];
      c6_b4_r   <= c5_b4_r;
      c6_b7_r   <= prod5[31:0];
    end
  end

  assign out_v    = v_r[5];
  assign out_b4   = c6_b4_r;
  assign out_b7   = c6_b7_r;
  assign out_side = side_r[5];

endmodule

FILE: design/bpc_comp.sv
module bpc_comp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [bpc_pkg::DIV_N-1:0] in_q,
  input  bpc_pkg::side_t            in_side,
  output logic                      out_v,
  output logic signed [15:0]        out_temp,
  output logic [17:0]               out_press,
  output logic                      out_err
);
  import bpc_pkg::*;

  logic               p1_v_r, p2_v_r, p3_v_r;
  side_t              p1_side_r, p2_side_r;
  logic [32:0]        p1_p_r, p2_p_r;
  logic [49:0]        p1_sq_r;
  logic signed [48:0] p1_m_r;
  logic [61:0]        p2_prod_r;
  logic signed [32:0] p2_x2_r;
  logic signed [15:0] p3_temp_r;
  logic [17:0]        p3_press_r;
  logic               p3_err_r;

  logic [32:0]        p;
  logic [24:0]        ps;
  logic signed [33:0] ps_s;
  logic signed [47:0] x1;
  logic signed [47:0] s;
  logic signed [48:0] pf;

  always_comb begin
    p    = in_side.b7hi ? {in_q, 1'b0} : {1'b0, in_q};
    ps   = p[32:8];
    ps_s = {1'b0, p};
    x1   = {2'b00, p2_prod_r[61:16]};
    s    = x1 + p2_x2_r + P_OFS;
    pf   = $signed({16'd0, p2_p_r}) + (s >>> 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= in_v;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_side_r <= in_side;
      p1_p_r    <= p;
      p1_sq_r   <= ps * ps;
      p1_m_r    <= P_COEF * ps_s;
      p2_side_r <= p1_side_r;
      p2_p_r    <= p1_p_r;
      p2_prod_r <= p1_sq_r * SQ_COEF;
      p2_x2_r   <= p1_m_r[48:16];
      p3_err_r  <= p2_side_r.err;
      p3_temp_r <= p2_side_r.err ? 16'sd0 : p2_side_r.temp;
      if (p2_side_r.err || pf[48]) begin
        p3_press_r <= '0;
      end else if (pf > $signed({31'd0, PRESS_MAX})) begin
        p3_press_r <= PRESS_MAX;
      end else begin
        p3_press_r <= pf[17:0];
      end
    end
  end

  assign out_v     = p3_v_r;
  assign out_temp  = p3_temp_r;
  assign out_press = p3_press_r;
  assign out_err   = p3_err_r;

endmodule

FILE: design/barometric_pressure_compensation.sv
// channel   | direction | beat contents (lowest bit up)
// ----------+-----------+-------------------------------------------------------
// in_       | slave     | raw_temp[15:0], raw_press[39:16]
// out_      | master    | temperature[15:0], pressure[33:16], calc_error[34]
// cfg_      | write     | cfg_index selects register, cfg_data written on cfg_wr_en
//
// one sample per cycle while not stalled; one input stage, two 32-stage
// restoring dividers (temperature and pressure quotients), one b5 stage, six
// coefficient stages and three correction stages, the last being the output
// register. reset (synchronous, rst_n low) clears valid bits and calibration.
// a stall on the output freezes the whole pipe together, so nothing is lost or
// repeated; bubbles are held in place behind a waiting result as well.
module barometric_pressure_compensation (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [39:0]                   in_tdata,   // raw_temp, raw_press
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // temperature, pressure, calc_error
  input  logic                          cfg_wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]     cfg_data
);
  import bpc_pkg::*;

  // calibration registers
  logic [31:0] ac1_ac2_r, ac3_ac4_r, ac5_ac6_r, b1_b2_r, mc_md_r;
  logic [1:0]  oss_r;
  cal_t        cal;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_ac2_r <= '0;
      ac3_ac4_r <= '0;
      ac5_ac6_r <= '0;
      b1_b2_r   <= '0;
      mc_md_r   <= '0;
      oss_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_AC1_AC2: ac1_ac2_r <= cfg_data;
        REG_AC3_AC4: ac3_ac4_r <= cfg_data;
        REG_AC5_AC6: ac5_ac6_r <= cfg_data;
        REG_B1_B2:   b1_b2_r   <= cfg_data;
        REG_MC_MD:   mc_md_r   <= cfg_data;
        REG_OSS:     oss_r     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.ac1 = ac1_ac2_r[31:16];
    cal.ac2 = ac1_ac2_r[15:0];
    cal.ac3 = ac3_ac4_r[31:16];
    cal.ac4 = ac3_ac4_r[15:0];
    cal.ac5 = ac5_ac6_r[31:16];
    cal.ac6 = ac5_ac6_r[15:0];
    cal.b1  = b1_b2_r[31:16];
    cal.b2  = b1_b2_r[15:0];
    cal.mc  = mc_md_r[31:16];
    cal.md  = mc_md_r[15:0];
    cal.oss = oss_r;
  end

  // whole pipe advances while the output register is free or being drained
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // input stage: (ut - ac6) * ac5 and shifted raw pressure
  logic               s1_v_r;
  logic signed [33:0] s1_prod_r;
  logic [23:0]        s1_up_r;
  logic signed [16:0] ut_d;
  logic signed [16:0] ac5_s;
  logic [23:0]        up;

  always_comb begin
    ut_d  = $signed({1'b0, in_tdata[15:0]}) - $signed({1'b0, cal.ac6});
    ac5_s = {1'b0, cal.ac5};
    up    = in_tdata[39:16] >> (4'd8 - {2'b00, cal.oss});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r <= ut_d * ac5_s;
      s1_up_r   <= up;
    end
  end

  // temperature divider operands: (mc * 2048) / (x1 + md), sign and magnitude
  logic signed [33:0]      x1_sh;
  logic signed [X1_W-1:0]  x1;
  logic signed [DEN_W-1:0] den;
  logic signed [DEN_W-1:0] den_neg;
  logic [16:0]             mc_abs;
  logic signed [16:0]      mc_neg;
  logic [DIV_N-1:0]        t_num;
  logic [DEN_W-1:0]        t_den;
  side_t                   t_side;

  always_comb begin
    x1_sh   = s1_prod_r >>> 15;
    x1      = x1_sh[X1_W-1:0];
    den     = x1 + cal.md;
    den_neg = -den;
    mc_neg  = -{cal.mc[15], cal.mc};
    mc_abs  = cal.mc[15] ? mc_neg : {1'b0, cal.mc};
    t_num   = {4'd0, mc_abs, 11'd0};
    t_den   = den[DEN_W-1] ? den_neg : den;
    t_side.err  = (den == '0);
    t_side.neg  = den[DEN_W-1] ^ cal.mc[15];
    t_side.b7hi = 1'b0;
    t_side.x1   = x1;
    t_side.up   = s1_up_r;
    t_side.temp = '0;
  end

  logic             d1_v;
  logic [DIV_N-1:0] d1_q;
  side_t            d1_side;

  bpc_div u_div_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (s1_v_r),
    .in_num   (t_num),
    .in_den   (t_den),
    .in_side  (t_side),
    .out_v    (d1_v),
    .out_q    (d1_q),
    .out_side (d1_side)
  );

  // b5 and saturated temperature
  logic               s3_v_r;
  logic signed [29:0] s3_b5_r;
  side_t              s3_side_r;
  logic signed [28:0] x2;
  logic signed [28:0] q_pos;
  logic signed [29:0] b5;
  logic signed [29:0] t;
  side_t              b5_side;

  always_comb begin
    q_pos   = {1'b0, d1_q[27:0]};
    x2      = d1_side.neg ? -q_pos : q_pos;
    b5      = d1_side.x1 + x2;
    t       = (b5 + 30'sd8) >>> 4;
    b5_side = d1_side;
    if (t > 30'sd32767) begin
      b5_side.temp = 16'sh7FFF;
    end else if (t < -30'sd32768) begin
      b5_side.temp = 16'sh8000;
    end else begin
      b5_side.temp = t[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_b5_r   <= b5;
      s3_side_r <= b5_side;
    end
  end

  // pressure coefficients b3, b4, b7
  logic        c_v;
  logic [16:0] c_b4;
  logic [31:0] c_b7;
  side_t       c_side;

  bpc_coef u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .cal      (cal),
    .in_v     (s3_v_r),
    .in_b5    (s3_b5_r),
    .in_side  (s3_side_r),
    .out_v    (c_v),
    .out_b4   (c_b4),
    .out_b7   (c_b7),
    .out_side (c_side)
  );

  // pressure quotient: doubled before the divide unless b7 has its top bit set
  logic [DIV_N-1:0] p_num;
  logic [DEN_W-1:0] p_den;
  side_t            p_side;

  always_comb begin
    p_num       = c_b7[31] ? c_b7 : {c_b7[30:0], 1'b0};
    p_den       = {3'd0, c_b4};
    p_side      = c_side;
    p_side.b7hi = c_b7[31];
    p_side.err  = c_side.err || (c_b4 == '0);
  end

  logic             d2_v;
  logic [DIV_N-1:0] d2_q;
  side_t            d2_side;

  bpc_div u_div_press (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (c_v),
    .in_num   (p_num),
    .in_den   (p_den),
    .in_side  (p_side),
    .out_v    (d2_v),
    .out_q    (d2_q),
    .out_side (d2_side)
  );

  // square-term correction and output register
  logic signed [15:0] temperature;
  logic [17:0]        pressure;
  logic               calc_error;

  bpc_comp u_comp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_v      (d2_v),
    .in_q      (d2_q),
    .in_side   (d2_side),
    .out_v     (out_tvalid),
    .out_temp  (temperature),
    .out_press (pressure),
    .out_err   (calc_error)
  );

  assign out_tdata = {5'd0, calc_error, pressure, temperature};

endmodule

FILE: design/bpc_check.sv
module bpc_check (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [39:0]                   out_tdata
);

  // an error beat carries zero temperature and pressure
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[34]) |-> (out_tdata[33:0] == 34'd0))
    else $error("error beat with non-zero payload");

  // input is taken exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  // nothing comes out straight after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat right after reset");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output beat changed");

endmodule

bind barometric_pressure_compensation bpc_check u_bpc_check (.*);

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int LIMIT   = 400000;  // cycles before the run is declared hung
  localparam int DRAIN   = 90;      // wait for the pipe to empty, with a margin
  localparam int N_PHASE = 9;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;     // raw_temp[15:0], raw_press[39:16]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // temperature[15:0], pressure[33:16], calc_error[34]
  logic        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // shadow copy of the calibration registers, indexed by register number
  logic [31:0] cal_shadow [6];

  logic [39:0] sample_q [$];   // samples waiting to be driven
  logic [34:0] comp_q [$];     // compensated results still to arrive
  bit          failed = 1'b0;
  bit          no_gaps = 1'b0;  // long stretch with no idling on either side
  int unsigned cycles = 0;

  barometric_pressure_compensation u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // integer compensation of one raw sample pair with the shadow calibration
  // returns {calc_error, pressure, temperature}
  function automatic logic [34:0] compensate(input logic [39:0] raw);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, up, x1, x2, x3, b3, b5, b6, t, p, sq;
    logic [1:0]  oss;
    logic [31:0] mult, prod, diff, scale, b4, b7;
    logic [63:0] quot;
    ac1 = $signed(cal_shadow[REG_AC1_AC2][31:16]);
    ac2 = $signed(cal_shadow[REG_AC1_AC2][15:0]);
    ac3 = $signed(cal_shadow[REG_AC3_AC4][31:16]);
    ac4 = cal_shadow[REG_AC3_AC4][15:0];
    ac5 = cal_shadow[REG_AC5_AC6][31:16];
    ac6 = cal_shadow[REG_AC5_AC6][15:0];
    b1  = $signed(cal_shadow[REG_B1_B2][31:16]);
    b2  = $signed(cal_shadow[REG_B1_B2][15:0]);
    mc  = $signed(cal_shadow[REG_MC_MD][31:16]);
    md  = $signed(cal_shadow[REG_MC_MD][15:0]);
    oss = cal_shadow[REG_OSS][1:0];
    ut  = raw[15:0];
    up  = raw[39:16] >> (8 - oss);

    x1 = ((ut - ac6) * ac5) >>> 15;
    // zero temperature divisor
    if (x1 + md == 0) return {1'b1, 34'd0};
    x2 = (mc * 2048) / (x1 + md);
    b5 = x1 + x2;
    t  = (b5 + 8) >>> 4;

    b6 = b5 - 4000;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    // b4 and b7 wrap at 32 bits as in the published scheme
    mult = 32'(x3 + 32768);
    prod = ac4[31:0] * mult;
    b4   = prod >> 15;
    if (b4 == 0) return {1'b1, 34'd0};
    diff  = 32'(up - b3);
    scale = 32'd50000 >> oss;
    b7    = diff * scale;
    if (b7 < 32'h8000_0000) quot = ({32'd0, b7} * 64'd2) / {32'd0, b4};
    else quot = ({32'd0, b7} / {32'd0, b4}) * 64'd2;
    p = longint'(quot);

    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    p  = p + ((x1 + x2 + 3791) >>> 4);

    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (p < 0) p = 0;
    if (p > 262143) p = 262143;
    return {1'b0, p[17:0], t[15:0]};
  endfunction

  // sender: predicts each accepted beat, then offers the next sample
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) comp_q.push_back(compensate(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() > 0 && (no_gaps || $urandom_range(99) >= 19)) begin
          in_tdata  <= sample_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random back-pressure, each beat checked against the oldest prediction
  always @(posedge clk) begin
    logic [34:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (comp_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_tdata[34:0]);
          failed = 1'b1;
        end else begin
          want = comp_q.pop_front();
          if (out_tdata[15:0] !== want[15:0]) begin
            $display("%0t: temperature expected %0d actual %0d", $time,
                     $signed(want[15:0]), $signed(out_tdata[15:0]));
            failed = 1'b1;
          end
          if (out_tdata[33:16] !== want[33:16]) begin
            $display("%0t: pressure expected %0d actual %0d", $time,
                     want[33:16], out_tdata[33:16]);
            failed = 1'b1;
          end
          if (out_tdata[34] !== want[34]) begin
            $display("%0t: calc_error expected %0b actual %0b", $time,
                     want[34], out_tdata[34]);
            failed = 1'b1;
          end
        end
      end
      out_tready <= no_gaps || ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("barometric_pressure_compensation verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    cal_shadow[idx] = (idx == REG_OSS) ? {30'd0, val[1:0]} : val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // waits until every prediction is answered and the pipe has emptied
  task automatic drain_pipe();
    while (sample_q.size() > 0 || comp_q.size() > 0 || in_tvalid) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // datasheet-like calibration set with an adjustable oversampling
  task automatic load_typical(input logic [1:0] oss);
    write_reg(REG_AC1_AC2, {16'sd408, -16'sd72});
    write_reg(REG_AC3_AC4, {-16'sd14383, 16'd32741});
    write_reg(REG_AC5_AC6, {16'd32757, 16'd23153});
    write_reg(REG_B1_B2, {16'sd6190, 16'sd4});
    write_reg(REG_MC_MD, {-16'sd8711, 16'sd2868});
    write_reg(REG_OSS, {30'd0, oss});
  endtask

  // random sample: mostly close to a plausible reading, sometimes anything
  function automatic logic [39:0] rand_sample();
    logic [15:0] ut;
    logic [23:0] rp;
    if ($urandom_range(3) == 0) begin
      ut = 16'($urandom);
      rp = 24'($urandom);
    end else begin
      ut = 16'($urandom_range(31000, 24000));
      rp = 24'($urandom_range(24'hA00000, 24'h400000));
    end
    return {rp, ut};
  endfunction

  initial begin
    for (int i = 0; i < 6; i++) cal_shadow[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: md and x1 are both zero, so every sample flags an error
    sample_q.push_back({24'h000000, 16'h0000});
    sample_q.push_back({24'hFFFFFF, 16'hFFFF});
    for (int i = 0; i < 6; i++) sample_q.push_back(rand_sample());
    drain_pipe();

    for (int ph = 0; ph < N_PHASE; ph++) begin
      case (ph)
        0, 1, 2, 3: load_typical(ph[1:0]);
        4: begin
          // all-ones coefficients
          for (int r = 0; r < 5; r++) write_reg(r[CFG_IDX_W-1:0], 32'hFFFF_FFFF);
          write_reg(REG_OSS, 32'd3);
        end
        5: begin
          // b1, md at signed max, ac6 zero; other coefficients most negative or largest
          write_reg(REG_AC1_AC2, 32'h8000_8000);
          write_reg(REG_AC3_AC4, 32'h8000_FFFF);
          write_reg(REG_AC5_AC6, 32'hFFFF_0000);
          write_reg(REG_B1_B2, 32'h7FFF_8000);
          write_reg(REG_MC_MD, 32'h8000_7FFF);
          write_reg(REG_OSS, 32'd0);
        end
        6: begin
          // ac4 zero: the b4 divisor is always zero
          load_typical(2'd1);
          write_reg(REG_AC3_AC4, {-16'sd14383, 16'd0});
        end
        7: begin
          // ac5 zero makes x1 zero, md zero then hits the temperature divisor
          load_typical(2'd2);
          write_reg(REG_AC5_AC6, {16'd0, 16'd23153});
          write_reg(REG_MC_MD, {-16'sd8711, 16'sd0});
        end
        default: begin
          for (int r = 0; r < 5; r++) write_reg(r[CFG_IDX_W-1:0], $urandom);
          write_reg(REG_OSS, $urandom);
        end
      endcase

      // field extremes and a textbook reading
      sample_q.push_back({24'h000000, 16'h0000});
      sample_q.push_back({24'hFFFFFF, 16'hFFFF});
      sample_q.push_back({24'h5D2300, 16'd27898});
      sample_q.push_back({24'hFFFFFF, 16'h0000});
      sample_q.push_back({24'h000000, 16'hFFFF});

      no_gaps = (ph == 2);
      for (int i = 0; i < 58; i++) sample_q.push_back(rand_sample());
      drain_pipe();
      no_gaps = 1'b0;
    end

    if (!failed) begin
      $display("barometric_pressure_compensation verification clean");
    end else begin
      $display("barometric_pressure_compensation verification failed");
    end
    $finish;
  end

endmodule
